@@ rtl/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  localparam int FifoDepth = 4;

  // Error codes reported on the result stream
  localparam logic [2:0] ErrNone    = 3'd0;
  localparam logic [2:0] ErrCtrl    = 3'd1;
  localparam logic [2:0] ErrEscape  = 3'd2;
  localparam logic [2:0] ErrHex     = 3'd3;
  localparam logic [2:0] ErrNoQuote = 3'd4;

  typedef enum logic [1:0] {
    OpByte  = 2'd0,  // one literal byte
    OpUtf8  = 2'd1,  // code point to be encoded as UTF-8
    OpClose = 2'd2,  // closing quote
    OpError = 2'd3   // error report
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] data;
    logic [2:0]  err;
  } op_t;

endpackage

@@ rtl/jsu_fifo.sv @@
// Short queue of decoded operations between front and back end.
module jsu_fifo #(
  parameter int Depth = jsu_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::op_t  push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output jsu_pkg::op_t  head_op_o,
  output logic          empty_o
);
  import jsu_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  op_t           mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o    = (count_q == CW'(Depth));
  assign empty_o   = (count_q == '0);
  assign head_op_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

@@ rtl/jsu_front.sv @@
// Front end: accepts raw bytes, tracks string/escape/hex mode, queues operations.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  output logic          push_o,
  output jsu_pkg::op_t  push_op_o,
  input  logic          full_i
);
  import jsu_pkg::*;

  localparam logic [1:0] ModeWait = 2'd0;
  localparam logic [1:0] ModeStr  = 2'd1;
  localparam logic [1:0] ModeEsc  = 2'd2;
  localparam logic [1:0] ModeHex  = 2'd3;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChCtrlMax = 8'd31;

  // {invalid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30;
        return {1'b0, t[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        t = c - 8'h57;
        return {1'b0, t[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        t = c - 8'h37;
        return {1'b0, t[3:0]};
      end
      return 5'h10;
    end
  endfunction

  logic [1:0]  mode_q, mode_d;
  logic [11:0] hex_q, hex_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic        accept;
  logic [4:0]  nib;
  logic        push;
  op_t         op;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign nib        = hex_nibble(in_byte_i);

  always_comb begin
    mode_d    = mode_q;
    hex_d     = hex_q;
    hex_cnt_d = hex_cnt_q;
    push      = 1'b0;
    op.kind   = OpByte;
    op.data   = {8'h00, in_byte_i};
    op.err    = ErrNone;
    unique case (mode_q)
      ModeStr: begin
        if (in_byte_i <= ChCtrlMax) begin
          push    = 1'b1;
          op.kind = OpError;
          op.err  = ErrCtrl;
          mode_d  = ModeWait;
        end else if (in_byte_i == ChBslash) begin
          mode_d = ModeEsc;
        end else if (in_byte_i == ChQuote) begin
          push    = 1'b1;
          op.kind = OpClose;
          mode_d  = ModeWait;
        end else begin
          push = 1'b1;
        end
      end
      ModeEsc: begin
        mode_d = ModeStr;
        push   = 1'b1;
        if (in_byte_i <= ChCtrlMax) begin
          op.kind = OpError;
          op.err  = ErrCtrl;
          mode_d  = ModeWait;
        end else begin
          unique case (in_byte_i)
            ChQuote, ChBslash, ChSlash: op.data = {8'h00, in_byte_i};
            8'h62: op.data = 16'h0008;  // b
            8'h66: op.data = 16'h000c;  // f
            8'h6e: op.data = 16'h000a;  // n
            8'h72: op.data = 16'h000d;  // r
            8'h74: op.data = 16'h0009;  // t
            8'h75: begin                // u
              push      = 1'b0;
              mode_d    = ModeHex;
              hex_d     = '0;
              hex_cnt_d = '0;
            end
            default: begin
              op.kind = OpError;
              op.err  = ErrEscape;
              mode_d  = ModeWait;
            end
          endcase
        end
      end
      ModeHex: begin
        if (nib[4]) begin
          push      = 1'b1;
          op.kind   = OpError;
          op.err    = ErrHex;
          mode_d    = ModeWait;
          hex_d     = '0;
          hex_cnt_d = '0;
        end else if (hex_cnt_q != 2'd3) begin
          hex_d     = {hex_q[7:0], nib[3:0]};
          hex_cnt_d = hex_cnt_q + 2'd1;
        end else begin
          push      = 1'b1;
          op.kind   = OpUtf8;
          op.data   = {hex_q, nib[3:0]};
          mode_d    = ModeStr;
          hex_d     = '0;
          hex_cnt_d = '0;
        end
      end
      default: begin
        if (in_byte_i == ChQuote) begin
          mode_d    = ModeStr;
          hex_d     = '0;
          hex_cnt_d = '0;
        end else begin
          push    = 1'b1;
          op.kind = OpError;
          op.err  = ErrNoQuote;
          mode_d  = ModeWait;
        end
      end
    endcase
  end

  assign push_o    = accept && push;
  assign push_op_o = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeWait;
      hex_q     <= '0;
      hex_cnt_q <= '0;
    end else if (accept) begin
      mode_q    <= mode_d;
      hex_q     <= hex_d;
      hex_cnt_q <= hex_cnt_d;
    end
  end

endmodule

@@ rtl/jsu_back.sv @@
// Back end: expands queued operations into result items, with output register.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jsu_pkg::op_t  head_op_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          last_o,
  output logic          closed_o,
  output logic [2:0]    err_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q;
  logic [7:0] byte_q, byte_d;
  logic       bvalid_q, bvalid_d;
  logic       last_q, last_d;
  logic       closed_q, closed_d;
  logic [2:0] err_q, err_d;
  logic       load;
  logic [1:0] n_last;  // index of the final result of a UTF-8 op
  logic [15:0] cp;

  assign cp   = head_op_i.data;
  assign load = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    if (cp[15:7] == '0) begin
      n_last = 2'd0;
    end else if (cp[15:11] == '0) begin
      n_last = 2'd1;
    end else begin
      n_last = 2'd2;
    end
  end

  always_comb begin
    byte_d   = 8'h00;
    bvalid_d = 1'b0;
    last_d   = 1'b1;
    closed_d = 1'b0;
    err_d    = ErrNone;
    unique case (head_op_i.kind)
      OpByte: begin
        byte_d   = cp[7:0];
        bvalid_d = 1'b1;
      end
      OpUtf8: begin
        bvalid_d = 1'b1;
        last_d   = (idx_q == n_last);
        if (idx_q == 2'd0) begin
          unique case (n_last)
            2'd0:    byte_d = cp[7:0];
            2'd1:    byte_d = {3'b110, cp[10:6]};
            default: byte_d = {4'b1110, cp[15:12]};
          endcase
        end else if (idx_q == 2'd1 && n_last == 2'd2) begin
          byte_d = {2'b10, cp[11:6]};
        end else begin
          byte_d = {2'b10, cp[5:0]};
        end
      end
      OpClose: closed_d = 1'b1;
      default: err_d = head_op_i.err;
    endcase
  end

  assign pop_o = load && last_d;
  assign idx_d = pop_o ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      bvalid_q <= bvalid_d;
      last_q   <= last_d;
      closed_q <= closed_d;
      err_q    <= err_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvalid_q;
  assign last_o       = last_q;
  assign closed_o     = closed_q;
  assign err_o        = err_q;

endmodule

@@ rtl/json_string_unescape.sv @@
// Top level of the streaming JSON string unescaper.
//
//  channel  dir  payload
//  s_axis   in   tdata[7:0] raw byte
//  m_axis   out  tdata[7:0] out byte, tlast last of run,
//                tuser[0] byte valid, [1] string closed, [4:2] error code
//
// One input byte is accepted per cycle while the operation queue has room.
// A \u escape that encodes to three UTF-8 bytes gives three result items from one
// queue entry; while the back end emits them, the queue absorbs input. Bytes that only
// advance the mode (opening quote, backslash, u, first three hex digits) give no item.
// Reset puts the decoder in the waiting state and empties queue and output.
module json_string_unescape #(
  parameter int FifoDepth = jsu_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic [4:0] m_axis_tuser    // [0] byte_valid, [1] string_closed, [4:2] error_code
);
  import jsu_pkg::*;

  logic push, full, pop, empty;
  op_t  push_op, head_op;
  logic bvalid, closed;
  logic [2:0] err;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .push_o     (push),
    .push_op_o  (push_op),
    .full_i     (full)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .head_op_o (head_op),
    .empty_o   (empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_op_i    (head_op),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .byte_valid_o (bvalid),
    .last_o       (m_axis_tlast),
    .closed_o     (closed),
    .err_o        (err)
  );

  assign m_axis_tuser = {err, closed, bvalid};

endmodule
